// ===== design/linear_probe_counter_map_top_macros.svh =====
// Assertion macros for the linear probe counter map.
// Included by files that carry concurrent checks; empty when SYNTH is set.
`ifndef LINEAR_PROBE_COUNTER_MAP_TOP_MACROS_SVH
`define LINEAR_PROBE_COUNTER_MAP_TOP_MACROS_SVH
`ifndef SYNTH
`define LPCM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LPCM_ASSERT_CLK(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
`else
`define LPCM_ASSERT(lbl, prop, msg)
`define LPCM_ASSERT_CLK(lbl, ck, rn, prop, msg)
`endif
`endif

// ===== design/lpcm_pkg.sv =====
// Shared types and constants for the linear probe counter map.
// No dependencies.
package lpcm_pkg;

    localparam int KEY_W        = 32;
    localparam int VAL_W        = 32;
    localparam int KEY_BYTES    = 4;
    localparam int SLOT_OUT_W   = 10;
    localparam int LIVE_OUT_W   = 11;
    localparam logic [31:0] HASH_SEED = 32'd5381;
    localparam int HASH_SHIFT   = 5;

    typedef enum logic [1:0] {
        REQ_ADD = 2'd0,
        REQ_GET = 2'd1,
        REQ_INC = 2'd2,
        REQ_DEL = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        MARK_EMPTY = 2'd0,
        MARK_LIVE  = 2'd1,
        MARK_TOMB  = 2'd2
    } mark_t;

    typedef struct packed {
        req_t              req;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
    } req_word_t;

    typedef struct packed {
        mark_t             mark;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
    } slot_word_t;

endpackage

// ===== design/lpcm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lpcm_ram #(
    parameter int WIDTH = 66,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/lpcm_queue.sv =====
// Two-entry FIFO between the front and back parts of the map.
// No dependencies.
module lpcm_queue #(
    parameter int WIDTH = 82
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                mem_reg[wr_ptr_reg] <= push_data;
                wr_ptr_reg          <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    assign pop_data = mem_reg[rd_ptr_reg];
    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);

endmodule

// ===== design/lpcm_front.sv =====
// Front part: takes request words, computes the djb2 home slot, queues them.
// Depends on lpcm_pkg and lpcm_queue.
module lpcm_front #(
    parameter int CAPACITY = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  lpcm_pkg::req_word_t           in_word,
    input  logic                          clearing,
    input  logic                          q_pop,
    output logic                          q_empty,
    output lpcm_pkg::req_word_t           q_word,
    output logic [$clog2(CAPACITY)-1:0]   q_home
);
    import lpcm_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int QW = $bits(req_word_t) + IW;

    logic            st_valid_reg;
    logic            st_valid_next;
    req_word_t       st_word_reg;
    logic [IW-1:0]   st_home_reg;
    logic [IW-1:0]   home;
    logic            accept;
    logic            push;
    logic            q_full;
    logic [QW-1:0]   q_data;

    // Only the low index bits of the hash matter: shift and add never carry down.
    always_comb
    begin
        home = IW'(HASH_SEED);
        for (int b = 0; b < KEY_BYTES; b++)
        begin
            home = (home << HASH_SHIFT) + home + IW'(in_word.key[8*b +: 8]);
        end
    end

    assign in_stall      = clearing || (st_valid_reg && q_full);
    assign accept        = in_valid && !in_stall;
    assign push          = st_valid_reg && !q_full;
    assign st_valid_next = accept || (st_valid_reg && !push);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= 1'b0;
        end
        else
        begin
            st_valid_reg <= st_valid_next;
            if (accept)
            begin
                st_word_reg <= in_word;
                st_home_reg <= home;
            end
        end
    end

    lpcm_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({st_word_reg, st_home_reg}),
        .pop       (q_pop),
        .pop_data  (q_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign q_word = q_data[QW-1:IW];
    assign q_home = q_data[IW-1:0];

endmodule

// ===== design/lpcm_back.sv =====
// Back part: clears the slot store after reset, probes it for each request,
// updates it and holds the result word. Depends on lpcm_pkg and lpcm_ram.
module lpcm_back #(
    parameter int CAPACITY = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_empty,
    input  lpcm_pkg::req_word_t                 q_word,
    input  logic [$clog2(CAPACITY)-1:0]         q_home,
    output logic                                q_pop,
    output logic                                clearing,
    output logic                                out_valid,
    input  logic                                out_stall,
    output lpcm_pkg::status_t                   status,
    output logic [lpcm_pkg::VAL_W-1:0]          found_value,
    output logic [lpcm_pkg::SLOT_OUT_W-1:0]     slot_index,
    output logic [lpcm_pkg::LIVE_OUT_W-1:0]     live_entries,
    output logic [$clog2(CAPACITY)-1:0]         live_count
);
    import lpcm_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam logic [IW-1:0] HALF_CAP = IW'(CAPACITY / 2);
    localparam logic [IW-1:0] LAST_SLOT = IW'(CAPACITY - 1);
    localparam logic [IW:0]   PROBE_MAX = (IW + 1)'(CAPACITY);

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_PROBE,
        B_RESULT
    } state_t;

    state_t                   state_reg,  state_next;
    logic [IW-1:0]            clr_cnt_reg, clr_cnt_next;
    logic [IW-1:0]            idx_reg,    idx_next;
    logic [IW:0]              n_reg,      n_next;
    req_word_t                cur_reg,    cur_next;
    logic [IW-1:0]            live_reg,   live_next;
    status_t                  res_status_reg, res_status_next;
    logic [VAL_W-1:0]         res_value_reg,  res_value_next;
    logic [IW-1:0]            res_slot_reg,   res_slot_next;
    logic                     out_valid_reg,  out_valid_next;
    status_t                  out_status_reg, out_status_next;
    logic [VAL_W-1:0]         out_value_reg,  out_value_next;
    logic [SLOT_OUT_W-1:0]    out_slot_reg,   out_slot_next;
    logic [LIVE_OUT_W-1:0]    out_live_reg,   out_live_next;

    logic                     we;
    logic [IW-1:0]            waddr;
    slot_word_t               wdata;
    logic [IW-1:0]            raddr;
    slot_word_t               rd;
    logic [$bits(slot_word_t)-1:0] rdata_raw;
    logic [IW-1:0]            idx_inc;
    logic [IW:0]              n_inc;

    assign rd      = rdata_raw;
    assign idx_inc = idx_reg + 1'b1;
    assign n_inc   = n_reg + 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        cur_next        = cur_reg;
        live_next       = live_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        res_slot_next   = res_slot_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_slot_next   = out_slot_reg;
        out_live_next   = out_live_reg;
        we              = 1'b0;
        waddr           = idx_reg;
        wdata           = '{mark: MARK_LIVE, key: cur_reg.key, value: cur_reg.value};
        raddr           = idx_reg;
        q_pop           = 1'b0;

        unique case (state_reg)
            B_CLEAR:
            begin
                we           = 1'b1;
                waddr        = clr_cnt_reg;
                wdata        = '{mark: MARK_EMPTY, key: '0, value: '0};
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_SLOT)
                begin
                    state_next = B_IDLE;
                end
            end

            B_IDLE:
            begin
                raddr = q_home;
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_word;
                    idx_next = q_home;
                    n_next   = '0;
                    // add refused when one more entry would pass half capacity
                    if (q_word.req == REQ_ADD && live_reg >= HALF_CAP)
                    begin
                        res_status_next = ST_FULL;
                        res_value_next  = '0;
                        res_slot_next   = '0;
                        state_next      = B_RESULT;
                    end
                    else
                    begin
                        state_next = B_PROBE;
                    end
                end
            end

            B_PROBE:
            begin
                if (cur_reg.req == REQ_ADD)
                begin
                    if (rd.mark != MARK_LIVE)
                    begin
                        we              = 1'b1;
                        live_next       = live_reg + 1'b1;
                        res_status_next = ST_OK;
                        res_value_next  = '0;
                        res_slot_next   = idx_reg;
                        state_next      = B_RESULT;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                        raddr    = idx_inc;
                        n_next   = n_inc;
                    end
                end
                else if (rd.mark == MARK_EMPTY)
                begin
                    res_status_next = ST_MISSING;
                    res_value_next  = '0;
                    res_slot_next   = '0;
                    state_next      = B_RESULT;
                end
                else if (rd.mark == MARK_LIVE && rd.key == cur_reg.key)
                begin
                    res_status_next = ST_OK;
                    res_slot_next   = idx_reg;
                    res_value_next  = '0;
                    state_next      = B_RESULT;
                    case (cur_reg.req)
                        REQ_GET:
                        begin
                            res_value_next = rd.value;
                        end
                        REQ_INC:
                        begin
                            we             = 1'b1;
                            wdata          = '{mark: MARK_LIVE, key: rd.key,
                                               value: rd.value + 1'b1};
                            res_value_next = rd.value + 1'b1;
                        end
                        REQ_DEL:
                        begin
                            we    = 1'b1;
                            wdata = '{mark: MARK_TOMB, key: rd.key, value: rd.value};
                            if (live_reg != '0)
                            begin
                                live_next = live_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                            res_value_next = '0;
                        end
                    endcase
                end
                else if (n_inc == PROBE_MAX)
                begin
                    // every slot visited without hitting an empty one
                    res_status_next = ST_MISSING;
                    res_value_next  = '0;
                    res_slot_next   = '0;
                    state_next      = B_RESULT;
                end
                else
                begin
                    idx_next = idx_inc;
                    raddr    = idx_inc;
                    n_next   = n_inc;
                end
            end

            B_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_value_next  = res_value_reg;
                    out_slot_next   = SLOT_OUT_W'(res_slot_reg);
                    out_live_next   = LIVE_OUT_W'(live_reg);
                    state_next      = B_IDLE;
                end
            end

            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_cnt_reg   <= '0;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            live_reg       <= live_next;
            out_valid_reg  <= out_valid_next;
            idx_reg        <= idx_next;
            n_reg          <= n_next;
            cur_reg        <= cur_next;
            res_status_reg <= res_status_next;
            res_value_reg  <= res_value_next;
            res_slot_reg   <= res_slot_next;
            out_status_reg <= out_status_next;
            out_value_reg  <= out_value_next;
            out_slot_reg   <= out_slot_next;
            out_live_reg   <= out_live_next;
        end
    end

    lpcm_ram #(
        .WIDTH ($bits(slot_word_t)),
        .DEPTH (CAPACITY)
    ) u_slots (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_raw)
    );

    assign clearing     = (state_reg == B_CLEAR);
    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign found_value  = out_value_reg;
    assign slot_index   = out_slot_reg;
    assign live_entries = out_live_reg;
    assign live_count   = live_reg;

endmodule

// ===== design/linear_probe_counter_map_top.sv =====
// Linear probe counter map: open-addressing key/value store with djb2 hashing.
// Depends on lpcm_pkg, lpcm_front, lpcm_back and the assertion macro header.
//
//  channel | valid     | stall     | fields
//  --------+-----------+-----------+-------------------------------------------
//  in      | in_valid  | in_stall  | req_type, key, value
//  out     | out_valid | out_stall | status, found_value, slot_index, live_entries
//
// In the back part a request passes the idle, probe and result states, reading one
// slot per cycle from the slot RAM while probing; a refused add skips the probe state.
// After reset a clearing pass marks all CAPACITY slots empty, one per cycle;
// in_stall is high during it. A two-word queue lets requests be taken while the
// back part probes or a result waits on out_stall.
`include "linear_probe_counter_map_top_macros.svh"
module linear_probe_counter_map_top #(
    parameter int CAPACITY = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         req_type,
    input  logic [lpcm_pkg::KEY_W-1:0]         key,
    input  logic [lpcm_pkg::VAL_W-1:0]         value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         status,
    output logic [lpcm_pkg::VAL_W-1:0]         found_value,
    output logic [lpcm_pkg::SLOT_OUT_W-1:0]    slot_index,
    output logic [lpcm_pkg::LIVE_OUT_W-1:0]    live_entries
);
    import lpcm_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam logic [IW-1:0] HALF_CAP = IW'(CAPACITY / 2);

    req_word_t       in_word;
    req_word_t       q_word;
    logic [IW-1:0]   q_home;
    logic            q_pop;
    logic            q_empty;
    logic            clearing;
    status_t         status_e;
    logic [IW-1:0]   live_count;
    logic            out_refused;
    logic            out_zero;

    assign in_word = '{req: req_t'(req_type), key: key, value: value};

    lpcm_front #(
        .CAPACITY (CAPACITY)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_word  (in_word),
        .clearing (clearing),
        .q_pop    (q_pop),
        .q_empty  (q_empty),
        .q_word   (q_word),
        .q_home   (q_home)
    );

    lpcm_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_word       (q_word),
        .q_home       (q_home),
        .q_pop        (q_pop),
        .clearing     (clearing),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status_e),
        .found_value  (found_value),
        .slot_index   (slot_index),
        .live_entries (live_entries),
        .live_count   (live_count)
    );

    assign status      = status_e;
    assign out_refused = out_valid && (status_e == ST_FULL || status_e == ST_MISSING);
    assign out_zero    = (found_value == '0) && (slot_index == '0);

    `LPCM_ASSERT(a_stall_while_clearing, clearing |-> in_stall, "word taken during clear")
    `LPCM_ASSERT(a_live_bound, live_count <= HALF_CAP, "live count above half capacity")
    `LPCM_ASSERT(a_refused_clean, out_refused |-> out_zero, "refused word carries data")
    `LPCM_ASSERT(a_no_pop_empty, q_pop |-> !q_empty, "queue popped while empty")

endmodule
